@@ rtl/core/apbc_pkg.sv @@
// Shared types and constants for the alignment path bundle classifier.
`default_nettype none

package apbc_pkg;

  // Target bundle geometry: offsets are four bits wide, so the tables hold 16 rows.
  localparam int MAX_BUNDLE = 16;
  localparam int OFF_BITS   = 4;
  localparam int SIZE_BITS  = 5;
  localparam int CFG_BITS   = 16;

  typedef logic [OFF_BITS-1:0]  off_t;
  typedef logic [SIZE_BITS-1:0] size_t;

  localparam size_t MAX_SIZE = size_t'(MAX_BUNDLE);

  // Request kinds on the input channel.
  localparam logic CMD_NODE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration register indexes.
  localparam logic CFG_FIRST_NODE  = 1'b0;
  localparam logic CFG_BUNDLE_SIZE = 1'b1;

  typedef enum logic [2:0] {
    CLS_QUERY      = 3'd0,
    CLS_UNCOUNTED  = 3'd1,
    CLS_BYPASS     = 3'd2,
    CLS_SPANNING   = 3'd3,
    CLS_UPSTREAM   = 3'd4,
    CLS_DOWNSTREAM = 3'd5
  } class_t;

  // Counter update request from the classifier to the count bank.
  typedef struct packed {
    logic   inc;
    class_t cls;
    off_t   offset;
  } bump_t;

endpackage

`default_nettype wire

@@ rtl/core/apbc_count_bank.sv @@
// Per-offset read count tables and bypass counter, saturating, read after update.
`default_nettype none

module apbc_count_bank #(
  parameter int COUNT_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire apbc_pkg::bump_t       bump,
  output logic      [COUNT_BITS-1:0] span_cnt,
  output logic      [COUNT_BITS-1:0] up_cnt,
  output logic      [COUNT_BITS-1:0] down_cnt,
  output logic      [COUNT_BITS-1:0] byp_cnt
);

  typedef logic [COUNT_BITS-1:0] count_t;

  count_t spanning_r   [apbc_pkg::MAX_BUNDLE];
  count_t upstream_r   [apbc_pkg::MAX_BUNDLE];
  count_t downstream_r [apbc_pkg::MAX_BUNDLE];
  count_t bypass_r;

  count_t span_nxt;
  count_t up_nxt;
  count_t down_nxt;
  count_t byp_nxt;

  function automatic count_t sat_inc(input count_t v);
    return (v == {COUNT_BITS{1'b1}}) ? v : v + COUNT_BITS'(1);
  endfunction

  always_comb begin
    span_nxt = spanning_r[bump.offset];
    up_nxt   = upstream_r[bump.offset];
    down_nxt = downstream_r[bump.offset];
    byp_nxt  = bypass_r;
    if (bump.inc) begin
      case (bump.cls)
        apbc_pkg::CLS_BYPASS:     byp_nxt  = sat_inc(bypass_r);
        apbc_pkg::CLS_SPANNING:   span_nxt = sat_inc(spanning_r[bump.offset]);
        apbc_pkg::CLS_UPSTREAM:   up_nxt   = sat_inc(upstream_r[bump.offset]);
        apbc_pkg::CLS_DOWNSTREAM: down_nxt = sat_inc(downstream_r[bump.offset]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < apbc_pkg::MAX_BUNDLE; i++) begin
        spanning_r[i]   <= '0;
        upstream_r[i]   <= '0;
        downstream_r[i] <= '0;
      end
      bypass_r <= '0;
    end else if (bump.inc) begin
      spanning_r[bump.offset]   <= span_nxt;
      upstream_r[bump.offset]   <= up_nxt;
      downstream_r[bump.offset] <= down_nxt;
      bypass_r                  <= byp_nxt;
    end
  end

  assign span_cnt = span_nxt;
  assign up_cnt   = up_nxt;
  assign down_cnt = down_nxt;
  assign byp_cnt  = byp_nxt;

endmodule

`default_nettype wire

@@ rtl/core/alignment_path_bundle_classifier.sv @@
// Top level: classifies alignment paths against a bundle of target nodes and keeps counts.
`default_nettype none

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-----------------------------------------------
// in_       | input     | in_valid/in_ready  | cmd, node_id, last_of_path, query_offset
// out_      | output    | out_valid/out_ready| class_code, target_offset, four counts
// cfg_      | input     | cfg_wr_en only     | cfg_index (0 first_node, 1 bundle_size), cfg_wdata
//
// One request per cycle sustained while no result is stalled. In the input register
// a request gets the range compare, path flags, classification and a single table
// increment, and its result (if any) is registered into the output register as it leaves.
// Reset (rst_n low, synchronous) clears the path flags, all count tables and the
// bypass counter at once, and loads first_node 0, bundle_size 1. A stalled result
// holds the output register; the input register still drains requests that give
// no result, and takes a new request in the cycle the result is taken.

module alignment_path_bundle_classifier #(
  parameter int NODE_BITS  = 16,
  parameter int COUNT_BITS = 32
) (
  input  wire  logic                          clk,
  input  wire  logic                          rst_n,
  // input channel
  input  wire  logic                          in_valid,
  output logic                                in_ready,
  input  wire  logic                          in_cmd,
  input  wire  logic [15:0]                   in_node_id,
  input  wire  logic                          in_last_of_path,
  input  wire  logic [3:0]                    in_query_offset,
  // result channel
  output logic                                out_valid,
  input  wire  logic                          out_ready,
  output logic [2:0]                          out_class_code,
  output logic [3:0]                          out_target_offset,
  output logic [31:0]                         out_spanning_count,
  output logic [31:0]                         out_upstream_count,
  output logic [31:0]                         out_downstream_count,
  output logic [31:0]                         out_bypass_count,
  // configuration
  input  wire  logic                          cfg_wr_en,
  input  wire  logic                          cfg_index,
  input  wire  logic [apbc_pkg::CFG_BITS-1:0] cfg_wdata
);

  typedef logic [NODE_BITS-1:0] node_t;
  typedef logic [NODE_BITS:0]   node_ext_t;   // one spare bit: the bundle end never wraps
  typedef logic [COUNT_BITS-1:0] count_t;

  // configuration
  node_t           first_node_r;
  apbc_pkg::size_t bundle_size_r;

  // input register
  logic            in_v_r;
  logic            cmd_r;
  node_t           node_r;
  logic            last_r;
  apbc_pkg::off_t  qoff_r;

  // path state
  logic            seen_up_r;
  logic            seen_down_r;
  logic            seen_tgt_r;
  apbc_pkg::off_t  overlap_r;

  // output register
  logic              out_v_r;
  apbc_pkg::class_t  out_cls_r;
  apbc_pkg::off_t    out_off_r;
  logic [31:0]       out_span_r;
  logic [31:0]       out_up_r;
  logic [31:0]       out_down_r;
  logic [31:0]       out_byp_r;

  // working signals
  apbc_pkg::size_t  eff_size;
  node_ext_t        bundle_hi;
  logic             below;
  logic             above;
  logic             up_nxt;
  logic             down_nxt;
  logic             tgt_nxt;
  apbc_pkg::off_t   overlap_nxt;
  logic             need_out;
  logic             advance;
  apbc_pkg::class_t cls;
  apbc_pkg::off_t   res_off;
  apbc_pkg::bump_t  bump;
  count_t           span_cnt;
  count_t           up_cnt;
  count_t           down_cnt;
  count_t           byp_cnt;

  // Bundle end: size 0 behaves as 1, anything above the table depth as the depth.
  always_comb begin
    if (bundle_size_r == '0) begin
      eff_size = apbc_pkg::size_t'(1);
    end else if (bundle_size_r > apbc_pkg::MAX_SIZE) begin
      eff_size = apbc_pkg::MAX_SIZE;
    end else begin
      eff_size = bundle_size_r;
    end
    bundle_hi = {1'b0, first_node_r} + (NODE_BITS+1)'(eff_size) - (NODE_BITS+1)'(1);
  end

  assign below = node_r < first_node_r;
  assign above = {1'b0, node_r} > bundle_hi;

  // Path flags as they stand after this node; the last inside node sets the offset.
  always_comb begin
    up_nxt      = seen_up_r | below;
    down_nxt    = seen_down_r | (!below && above);
    tgt_nxt     = seen_tgt_r | (!below && !above);
    overlap_nxt = (!below && !above) ? apbc_pkg::off_t'(node_r - first_node_r) : overlap_r;
  end

  // Classification at path end, first match wins.
  always_comb begin
    cls     = apbc_pkg::CLS_UNCOUNTED;
    res_off = tgt_nxt ? overlap_nxt : '0;
    if (cmd_r == apbc_pkg::CMD_QUERY) begin
      cls     = apbc_pkg::CLS_QUERY;
      res_off = qoff_r;
    end else if (up_nxt && down_nxt) begin
      cls = tgt_nxt ? apbc_pkg::CLS_SPANNING : apbc_pkg::CLS_BYPASS;
    end else if (up_nxt && tgt_nxt) begin
      cls = apbc_pkg::CLS_UPSTREAM;
    end else if (tgt_nxt && down_nxt) begin
      cls = apbc_pkg::CLS_DOWNSTREAM;
    end
  end

  // A request moves on when it gives no result or the output register is free.
  assign need_out = (cmd_r == apbc_pkg::CMD_QUERY) || last_r;
  assign advance  = in_v_r && (!need_out || !out_v_r || out_ready);
  assign in_ready = !in_v_r || advance;

  always_comb begin
    bump.inc    = advance && (cmd_r == apbc_pkg::CMD_NODE) && last_r &&
                  (cls != apbc_pkg::CLS_UNCOUNTED);
    bump.cls    = cls;
    bump.offset = res_off;
  end

  apbc_count_bank #(
    .COUNT_BITS (COUNT_BITS)
  ) u_bank (
    .clk      (clk),
    .rst_n    (rst_n),
    .bump     (bump),
    .span_cnt (span_cnt),
    .up_cnt   (up_cnt),
    .down_cnt (down_cnt),
    .byp_cnt  (byp_cnt)
  );

  // Configuration registers; a write takes effect at the edge it is seen.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_node_r  <= '0;
      bundle_size_r <= apbc_pkg::size_t'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        apbc_pkg::CFG_FIRST_NODE:  first_node_r  <= NODE_BITS'(cfg_wdata);
        apbc_pkg::CFG_BUNDLE_SIZE: bundle_size_r <= cfg_wdata[apbc_pkg::SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_v_r <= 1'b1;
    end else if (advance) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r  <= in_cmd;
      node_r <= NODE_BITS'(in_node_id);
      last_r <= in_last_of_path;
      qoff_r <= in_query_offset;
    end
  end

  // Path state: queries leave it alone, path end clears it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_up_r   <= 1'b0;
      seen_down_r <= 1'b0;
      seen_tgt_r  <= 1'b0;
      overlap_r   <= '0;
    end else if (advance && (cmd_r == apbc_pkg::CMD_NODE)) begin
      if (last_r) begin
        seen_up_r   <= 1'b0;
        seen_down_r <= 1'b0;
        seen_tgt_r  <= 1'b0;
        overlap_r   <= '0;
      end else begin
        seen_up_r   <= up_nxt;
        seen_down_r <= down_nxt;
        seen_tgt_r  <= tgt_nxt;
        overlap_r   <= overlap_nxt;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance && need_out) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && need_out) begin
      out_cls_r  <= cls;
      out_off_r  <= res_off;
      out_span_r <= 32'(span_cnt);
      out_up_r   <= 32'(up_cnt);
      out_down_r <= 32'(down_cnt);
      out_byp_r  <= 32'(byp_cnt);
    end
  end

  assign out_valid            = out_v_r;
  assign out_class_code       = out_cls_r;
  assign out_target_offset    = out_off_r;
  assign out_spanning_count   = out_span_r;
  assign out_upstream_count   = out_up_r;
  assign out_downstream_count = out_down_r;
  assign out_bypass_count     = out_byp_r;

endmodule

`default_nettype wire

@@ verif/alignment_path_bundle_classifier_test.sv @@
// Self-checking testbench for the alignment path bundle classifier.
module alignment_path_bundle_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest run of cycles with no request moving on either channel. The long
  // receiver hold-off below is well within this; everything else is far shorter.
  localparam int STALL_LIMIT   = 3000;
  // Input register plus output register, with some margin.
  localparam int SETTLE_CYCLES = 6;

  // How a random path node relates to the bundle.
  typedef enum int {
    NODE_UP   = 0,
    NODE_IN   = 1,
    NODE_DOWN = 2,
    NODE_ANY  = 3
  } node_kind_t;

  // One result as the block should present it.
  typedef struct {
    apbc_pkg::class_t cls;
    apbc_pkg::off_t   offset;
    logic [31:0]      spanning;
    logic [31:0]      upstream;
    logic [31:0]      downstream;
    logic [31:0]      bypass;
  } count_report_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [15:0] in_node_id;
  logic        in_last_of_path;
  logic [3:0]  in_query_offset;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_class_code;
  logic [3:0]  out_target_offset;
  logic [31:0] out_spanning_count;
  logic [31:0] out_upstream_count;
  logic [31:0] out_downstream_count;
  logic [31:0] out_bypass_count;
  logic        cfg_wr_en;
  logic        cfg_index;
  logic [apbc_pkg::CFG_BITS-1:0] cfg_wdata;

  alignment_path_bundle_classifier dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_cmd               (in_cmd),
    .in_node_id           (in_node_id),
    .in_last_of_path      (in_last_of_path),
    .in_query_offset      (in_query_offset),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_class_code       (out_class_code),
    .out_target_offset    (out_target_offset),
    .out_spanning_count   (out_spanning_count),
    .out_upstream_count   (out_upstream_count),
    .out_downstream_count (out_downstream_count),
    .out_bypass_count     (out_bypass_count),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the registers, path flags and counts.
  // ---------------------------------------------------------------------------
  logic [15:0]    bundle_first;
  logic [4:0]     bundle_size_reg;
  bit             seen_up;
  bit             seen_down;
  bit             seen_tgt;
  apbc_pkg::off_t last_overlap;
  logic [31:0]    span_tab [apbc_pkg::MAX_BUNDLE];
  logic [31:0]    up_tab   [apbc_pkg::MAX_BUNDLE];
  logic [31:0]    down_tab [apbc_pkg::MAX_BUNDLE];
  logic [31:0]    bypass_total;

  count_report_t expected_reports[$];

  int mismatches    = 0;
  int requests_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_left = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Counters stick at all ones.
  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  // Last target node id, computed one bit wider so a bundle near the top
  // of the id space runs off the end instead of wrapping.
  function automatic logic [16:0] bundle_last();
    logic [16:0] eff;
    if (bundle_size_reg == '0) eff = 17'd1;
    else if (bundle_size_reg > apbc_pkg::MAX_BUNDLE) eff = 17'(apbc_pkg::MAX_BUNDLE);
    else eff = 17'(bundle_size_reg);
    return {1'b0, bundle_first} + eff - 17'd1;
  endfunction

  function automatic count_report_t tally_at(apbc_pkg::class_t c, apbc_pkg::off_t o);
    count_report_t r;
    r.cls        = c;
    r.offset     = o;
    r.spanning   = span_tab[o];
    r.upstream   = up_tab[o];
    r.downstream = down_tab[o];
    r.bypass     = bypass_total;
    return r;
  endfunction

  // Append one expected result at the tail of the queue.
  task automatic queue_report(count_report_t r);
    expected_reports.insert(expected_reports.size(), r);
  endtask

  // Advance the predictor by one accepted request and queue what it yields.
  task automatic predict_request(logic cmd, logic [15:0] node, logic last,
                                 apbc_pkg::off_t qoff);
    logic [16:0]      top;
    apbc_pkg::off_t   off;
    apbc_pkg::class_t cls;
    top = bundle_last();
    if (cmd == apbc_pkg::CMD_QUERY) begin
      // a query never disturbs the path flags
      queue_report(tally_at(apbc_pkg::CLS_QUERY, qoff));
    end else begin
      if (node < bundle_first) seen_up = 1'b1;
      else if ({1'b0, node} > top) seen_down = 1'b1;
      else begin
        seen_tgt     = 1'b1;
        last_overlap = apbc_pkg::off_t'(node - bundle_first);   // later target node wins
      end
      if (last) begin
        off = seen_tgt ? last_overlap : apbc_pkg::off_t'(0);
        if (seen_up && seen_down && !seen_tgt) begin
          bypass_total = bump(bypass_total);
          cls = apbc_pkg::CLS_BYPASS;
        end else if (seen_up && seen_down) begin
          span_tab[off] = bump(span_tab[off]);
          cls = apbc_pkg::CLS_SPANNING;
        end else if (seen_up && seen_tgt) begin
          up_tab[off] = bump(up_tab[off]);
          cls = apbc_pkg::CLS_UPSTREAM;
        end else if (seen_tgt && seen_down) begin
          down_tab[off] = bump(down_tab[off]);
          cls = apbc_pkg::CLS_DOWNSTREAM;
        end else begin
          cls = apbc_pkg::CLS_UNCOUNTED;
        end
        // counts shown are those after this path's increment
        queue_report(tally_at(cls, off));
        seen_up      = 1'b0;
        seen_down    = 1'b0;
        seen_tgt     = 1'b0;
        last_overlap = '0;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus plumbing.
  // ---------------------------------------------------------------------------

  // Offer one request; valid stays up with the payload held until taken.
  task automatic send_request(logic cmd, logic [15:0] node, logic last,
                              apbc_pkg::off_t qoff);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_node_id      <= node;
    in_last_of_path <= last;
    in_query_offset <= qoff;
    do @(posedge clk); while (!in_ready);
    predict_request(cmd, node, last, qoff);
    requests_sent++;
  endtask

  // Query offset is a don't-care on node requests, so it is randomised.
  task automatic send_node(logic [15:0] node, logic last);
    send_request(apbc_pkg::CMD_NODE, node, last, apbc_pkg::off_t'($urandom));
  endtask

  // Likewise node id and last flag on queries.
  task automatic send_query(apbc_pkg::off_t qoff);
    send_request(apbc_pkg::CMD_QUERY, 16'($urandom), 1'($urandom), qoff);
  endtask

  // Drop valid and let every outstanding result come back; the extra cycles
  // cover node requests still in flight that produce nothing.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called with the block idle. Enable goes low for a cycle between writes.
  task automatic write_reg(logic idx, logic [apbc_pkg::CFG_BITS-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == apbc_pkg::CFG_FIRST_NODE) bundle_first = data;
    else bundle_size_reg = data[4:0];
    @(posedge clk);
  endtask

  // Pick a node id of the wanted kind for the current bundle, with the ids
  // either side of each bundle boundary favoured.
  function automatic logic [15:0] pick_node(node_kind_t kind);
    logic [16:0] top;
    int unsigned lo;
    int unsigned hi;
    top = bundle_last();
    lo  = bundle_first;
    hi  = (top > 17'd65535) ? 65535 : int'(top);
    case (kind)
      NODE_UP: begin
        if (lo == 0) return 16'($urandom);          // nothing lies upstream
        else if ($urandom_range(3) == 0) return 16'(lo - 1);
        else return 16'($urandom_range(lo - 1, 0));
      end
      NODE_IN: begin
        if ($urandom_range(3) == 0) return 16'($urandom_range(1) ? lo : hi);
        else return 16'($urandom_range(hi, lo));
      end
      NODE_DOWN: begin
        if (top >= 17'd65535) return 16'($urandom); // nothing lies downstream
        else if ($urandom_range(3) == 0) return 16'(top + 17'd1);
        else return 16'($urandom_range(65535, int'(top) + 1));
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // One path shaped towards a class, with the odd query dropped in mid-path.
  // Bit positions of the mask follow node_kind_t.
  task automatic random_path();
    logic [3:0] allowed;
    node_kind_t kind;
    int         len;
    case ($urandom_range(9))
      0, 1:    allowed = 4'b0101;   // bypass
      2, 3:    allowed = 4'b0111;   // spanning
      4, 5:    allowed = 4'b0011;   // upstream flank
      6, 7:    allowed = 4'b0110;   // downstream flank
      8:       allowed = 4'b1111;   // mixed
      default: allowed = 4'b1000;   // noise
    endcase
    len = $urandom_range(6, 1);
    for (int i = 0; i < len; i++) begin
      do kind = node_kind_t'($urandom_range(3)); while (!allowed[kind]);
      if ($urandom_range(9) == 0) send_query(apbc_pkg::off_t'($urandom));
      send_node(pick_node(kind), i == len - 1);
    end
  endtask

  // New bundle geometry, biased to the corners of both registers.
  task automatic randomise_config();
    logic [15:0] first;
    logic [4:0]  sz;
    case ($urandom_range(4))
      0:       first = 16'h0000;
      1:       first = 16'hFFFF;
      2:       first = 16'hFFF0 | 16'($urandom_range(15));
      default: first = 16'($urandom);
    endcase
    case ($urandom_range(5))
      0:       sz = 5'd1;
      1:       sz = 5'd16;
      2:       sz = 5'($urandom_range(31, 17));   // clamps to a full bundle
      3:       sz = 5'($urandom);                  // zero included
      default: sz = 5'($urandom_range(16, 1));
    endcase
    write_reg(apbc_pkg::CFG_FIRST_NODE, first);
    write_reg(apbc_pkg::CFG_BUNDLE_SIZE, apbc_pkg::CFG_BITS'(sz));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: receiver stalls and the checker.
  // ---------------------------------------------------------------------------

  // Random stalls, or a solid hold-off when one is requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_left > 0) begin
        out_ready <= 1'b0;
        hold_off_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic report_failure(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_failure($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  initial begin : result_checker
    count_report_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          report_failure("result arrived with nothing outstanding");
        end else begin
          want = expected_reports.pop_front();
          check_field("class_code",       32'(out_class_code),    32'(want.cls));
          check_field("target_offset",    32'(out_target_offset), 32'(want.offset));
          check_field("spanning_count",   out_spanning_count,     want.spanning);
          check_field("upstream_count",   out_upstream_count,     want.upstream);
          check_field("downstream_count", out_downstream_count,   want.downstream);
          check_field("bypass_count",     out_bypass_count,       want.bypass);
        end
      end
    end
  end

  // Ends the run if traffic stops moving on both channels.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("alignment_path_bundle_classifier test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Every class at least once, on bundle 100..103, plus queries.
  task automatic test_directed_classes();
    write_reg(apbc_pkg::CFG_FIRST_NODE, 16'd100);
    write_reg(apbc_pkg::CFG_BUNDLE_SIZE, 16'd4);
    send_query(apbc_pkg::off_t'(0));    // all zero straight after reset
    send_query(apbc_pkg::off_t'(15));
    send_node(16'd50, 1'b0);         // bypass: before then after, no target
    send_node(16'd200, 1'b1);
    send_node(16'd50, 1'b0);         // spanning, later target node replaces offset
    send_node(16'd101, 1'b0);
    send_node(16'd103, 1'b0);
    send_node(16'd300, 1'b1);
    send_node(16'd0, 1'b0);          // upstream flank from the lowest id
    send_node(16'd102, 1'b1);
    send_node(16'd100, 1'b0);        // downstream flank to the highest id
    send_node(16'hFFFF, 1'b1);
    send_node(16'd101, 1'b1);        // target only: uncounted
    send_node(16'd20, 1'b1);         // no target: uncounted, offset 0 shown
    send_node(16'd50, 1'b0);         // query in mid-path leaves flags alone
    send_query(apbc_pkg::off_t'(3));
    send_node(16'd102, 1'b0);
    send_node(16'd400, 1'b1);
    wait_idle();
  endtask

  // Size clamping, a bundle hanging off the top of the id space, and a
  // register write part-way through a path.
  task automatic test_config_corners();
    write_reg(apbc_pkg::CFG_BUNDLE_SIZE, 16'd0);        // zero acts as one
    send_node(16'd99, 1'b0);
    send_node(16'd100, 1'b0);
    send_node(16'd101, 1'b1);
    wait_idle();
    write_reg(apbc_pkg::CFG_FIRST_NODE, 16'd65530);
    write_reg(apbc_pkg::CFG_BUNDLE_SIZE, 16'd31);       // clamps to a full bundle
    send_node(16'd65529, 1'b0);
    send_node(16'd65535, 1'b1);
    wait_idle();
    write_reg(apbc_pkg::CFG_FIRST_NODE, 16'd10);
    write_reg(apbc_pkg::CFG_BUNDLE_SIZE, 16'd2);
    send_node(16'd5, 1'b0);                   // upstream of 10..11
    wait_idle();
    write_reg(apbc_pkg::CFG_FIRST_NODE, 16'd4);         // path continues on 4..5
    send_node(16'd5, 1'b1);
    wait_idle();
  endtask

  // Random paths in four chunks, each on a fresh bundle set while idle.
  task automatic test_random_traffic(int s_pct, int r_pct, int n);
    int stop_at;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int chunk = 0; chunk < 4; chunk++) begin
      wait_idle();
      randomise_config();
      stop_at = requests_sent + n / 4;
      while (requests_sent < stop_at) random_path();
    end
    wait_idle();
  endtask

  // Receiver holds off while the sender keeps offering requests, so the
  // pipeline fills and in_ready drops.
  task automatic test_backpressure();
    int stop_at;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_idle();
    randomise_config();
    hold_off_left = 300;
    stop_at = requests_sent + 60;
    while (requests_sent < stop_at) random_path();
    wait_idle();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_cmd          = apbc_pkg::CMD_NODE;
    in_node_id      = '0;
    in_last_of_path = 1'b0;
    in_query_offset = '0;
    cfg_wr_en       = 1'b0;
    cfg_index       = apbc_pkg::CFG_FIRST_NODE;
    cfg_wdata       = '0;

    // Predictor starts from the reset state.
    bundle_first    = '0;
    bundle_size_reg = 5'd1;
    seen_up         = 1'b0;
    seen_down       = 1'b0;
    seen_tgt        = 1'b0;
    last_overlap    = '0;
    bypass_total    = '0;
    for (int i = 0; i < apbc_pkg::MAX_BUNDLE; i++) begin
      span_tab[i] = '0;
      up_tab[i]   = '0;
      down_tab[i] = '0;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 16;
    recv_idle_pct = 46;
    test_directed_classes();
    test_config_corners();
    test_random_traffic(16, 46, 480);
    test_random_traffic(46, 16, 480);
    test_random_traffic(0, 0, 480);
    test_backpressure();

    // wait_idle leaves nothing outstanding; give stray results time to show.
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("alignment_path_bundle_classifier test passed");
    else $display("alignment_path_bundle_classifier test failed");
    $finish;
  end

endmodule
